>>> src/assert_macros.svh
// Assertion macros shared by the sampler RTL; clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(label, cond)
`define ASSERT_NEXT(label, trig, cond)

`endif

`endif

>>> src/htp_pkg.sv
// Types, constants and the oversampling table of the hash-to-point sampler.
`default_nettype none

package htp_pkg;

    // Field widths of the item and result channels.
    localparam int KIND_W     = 2;
    localparam int WORD_W     = 16;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int COEF_W     = 14;
    localparam int LOG_W      = 4;
    localparam int OVER_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Sampling constants.
    localparam logic [WORD_W-1:0]  REJECT_LIMIT  = 16'd61445;
    localparam logic [WORD_W-1:0]  MODULUS       = 16'd12289;
    localparam logic [WORD_W-1:0]  TWICE_MODULUS = 16'd24578;
    localparam logic [WORD_W-1:0]  EMPTY_SLOT    = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 11'd2047;

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_PUSH  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_DEGREE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDED_MODE = 1'd1;

    // Extra words consumed in bounded mode, by log2 of the degree.
    function automatic logic [OVER_W-1:0] oversample(input logic [LOG_W-1:0] lg);
        logic [OVER_W-1:0] val;
        begin
            case (lg)
                4'd1:    val = 9'd65;
                4'd2:    val = 9'd67;
                4'd3:    val = 9'd71;
                4'd4:    val = 9'd77;
                4'd5:    val = 9'd86;
                4'd6:    val = 9'd100;
                4'd7:    val = 9'd122;
                4'd8:    val = 9'd154;
                4'd9:    val = 9'd205;
                4'd10:   val = 9'd287;
                default: val = 9'd0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

>>> src/htp_in_if.sv
// Item channel of the sampler: kind, hash word and read index.
`default_nettype none

interface htp_in_if import htp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  hash_word;
    logic [INDEX_W-1:0] read_index;

    modport source (output valid, output kind, output hash_word, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input hash_word, input read_index,
                    output ready);
endinterface

`default_nettype wire

>>> src/htp_out_if.sv
// Result channel of the sampler: coefficient, ready flag and fill count.
`default_nettype none

interface htp_out_if import htp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  coefficient;
    logic               ready_res;
    logic [COUNT_W-1:0] filled_total;

    modport source (output valid, output coefficient, output ready_res,
                    output filled_total, input ready);
    modport sink   (input valid, input coefficient, input ready_res,
                    input filled_total, output ready);
endinterface

`default_nettype wire

>>> src/htp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module htp_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/hash_to_point_sampler.sv
// Top level of the hash-to-point rejection sampler modulo 12289.
`default_nettype none
`include "assert_macros.svh"

// Start and push items are taken one per cycle: a push compares the word, reduces it
// and writes it into the coefficient RAM in the cycle it is accepted. A read item
// issues a RAM read on acceptance; its result passes through the RAM's read register
// and then the output register. Items keep flowing one per cycle while a result
// waits; input stalls only when a second read result has nowhere to go.
// The coefficient RAM is not cleared: slots at or above the fill count or the degree
// read as 65535 whatever the RAM holds, so the block is usable right after reset.
module hash_to_point_sampler import htp_pkg::*; #(
    parameter int MAX_COEFS      = 1024,
    parameter int MAX_LOG_DEGREE = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    htp_in_if.sink                     items,
    htp_out_if.source                  results
);

    localparam int ADDR_W = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_COEFS);
    localparam logic [LOG_W-1:0]   MAX_LOG   = LOG_W'(MAX_LOG_DEGREE);

    // Configuration registers.
    logic [LOG_W-1:0] log_degree_reg;
    logic             bounded_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_degree_reg   <= 4'd9;
            bounded_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOG_DEGREE:   log_degree_reg   <= cfg_data;
                CFG_BOUNDED_MODE: bounded_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Degree, word limit and batch status from the current settings.
    logic [LOG_W-1:0]   eff_log;
    logic [COUNT_W-1:0] pow_n;
    logic [COUNT_W-1:0] degree_n;
    logic [COUNT_W-1:0] word_limit;
    logic [COUNT_W-1:0] filled_count_reg;
    logic [COUNT_W-1:0] words_taken_reg;
    logic               batch_ready;

    assign eff_log    = (log_degree_reg > MAX_LOG) ? MAX_LOG : log_degree_reg;
    assign pow_n      = COUNT_W'(1) << eff_log;
    assign degree_n   = (pow_n > MAX_COUNT) ? MAX_COUNT : pow_n;
    assign word_limit = degree_n + COUNT_W'(oversample(eff_log));
    assign batch_ready = bounded_mode_reg ? (words_taken_reg >= word_limit)
                                          : (filled_count_reg >= degree_n);

    // Handshake on the item side.
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_stall;
    logic in_fire;
    kind_t in_kind;

    assign s1_stall    = s1_valid_reg && out_valid_reg && !results.ready;
    assign items.ready = !s1_stall;
    assign in_fire     = items.valid && items.ready;
    assign in_kind     = kind_t'(items.kind);

    // Rejection test and reduction of a pushed word.
    logic [WORD_W-1:0] red_a;
    logic [WORD_W-1:0] red_b;
    logic [WORD_W-1:0] red_c;
    logic              word_ok;

    assign word_ok = items.hash_word < REJECT_LIMIT;
    assign red_a = (items.hash_word >= TWICE_MODULUS) ? items.hash_word - TWICE_MODULUS
                                                      : items.hash_word;
    assign red_b = (red_a >= TWICE_MODULUS) ? red_a - TWICE_MODULUS : red_a;
    assign red_c = (red_b >= MODULUS) ? red_b - MODULUS : red_b;

    // Counter updates and store writes.
    logic               push_ok;
    logic               store_we;
    logic               read_go;
    logic               read_hit;
    logic [COUNT_W-1:0] filled_count_next;
    logic [COUNT_W-1:0] words_taken_next;

    assign push_ok  = in_fire && (in_kind == KIND_PUSH) && !batch_ready;
    assign store_we = push_ok && word_ok && (filled_count_reg < degree_n);
    assign read_go  = in_fire && (in_kind == KIND_READ);
    assign read_hit = ({1'b0, items.read_index} < degree_n)
                   && ({1'b0, items.read_index} < filled_count_reg);

    always_comb
    begin
        filled_count_next = filled_count_reg;
        words_taken_next  = words_taken_reg;
        if (in_fire)
        begin
            case (in_kind)
                KIND_START:
                begin
                    filled_count_next = '0;
                    words_taken_next  = '0;
                end
                KIND_PUSH:
                begin
                    if (push_ok && (words_taken_reg < COUNT_MAX))
                    begin
                        words_taken_next = words_taken_reg + COUNT_W'(1);
                    end
                    if (store_we)
                    begin
                        filled_count_next = filled_count_reg + COUNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_count_reg <= '0;
            words_taken_reg  <= '0;
        end
        else
        begin
            filled_count_reg <= filled_count_next;
            words_taken_reg  <= words_taken_next;
        end
    end

    // Coefficient store.
    logic [COEF_W-1:0] ram_rdata;

    htp_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_COEFS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (filled_count_reg[ADDR_W-1:0]),
        .wdata (red_c[COEF_W-1:0]),
        .re    (read_go),
        .raddr (items.read_index[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Read stage: status captured while the RAM read is in flight.
    logic               s1_hit_reg;
    logic               s1_ready_reg;
    logic [COUNT_W-1:0] s1_filled_reg;
    logic               s1_advance;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (read_go)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_go)
        begin
            s1_hit_reg    <= read_hit;
            s1_ready_reg  <= batch_ready;
            s1_filled_reg <= filled_count_reg;
        end
    end

    // Output register.
    logic [WORD_W-1:0]  out_coef_reg;
    logic               out_ready_res_reg;
    logic [COUNT_W-1:0] out_filled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_coef_reg      <= s1_hit_reg ? {{(WORD_W-COEF_W){1'b0}}, ram_rdata}
                                            : EMPTY_SLOT;
            out_ready_res_reg <= s1_ready_reg;
            out_filled_reg    <= s1_filled_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.coefficient  = out_coef_reg;
    assign results.ready_res    = out_ready_res_reg;
    assign results.filled_total = out_filled_reg;

    // Checks on the fill and word counters and the read path.
    `ASSERT_ALWAYS(a_fill_bound, filled_count_reg <= MAX_COUNT)
    `ASSERT_NEXT(a_fill_step, !(in_fire && (in_kind == KIND_START)),
        (filled_count_reg == $past(filled_count_reg))
        || (filled_count_reg == $past(filled_count_reg) + COUNT_W'(1)))
    `ASSERT_NEXT(a_words_hold, !(in_fire && (in_kind == KIND_START || in_kind == KIND_PUSH)),
        words_taken_reg == $past(words_taken_reg))
    `ASSERT_NEXT(a_read_moves, s1_valid_reg && (!out_valid_reg || results.ready),
        out_valid_reg)

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench of the hash-to-point sampler: random push, start, read and no-op items.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import htp_pkg::*;

    localparam int TB_MAX_COEFS  = 1024;
    localparam int TB_MAX_LOG    = 10;
    localparam int ITEM_TARGET   = 750;
    localparam int unsigned SAT_COUNT = 2047;
    localparam int unsigned EXTRA_WORDS [11] =
        '{0, 65, 67, 71, 77, 86, 100, 122, 154, 205, 287};

    // One result of a read item.
    typedef struct {
        logic [WORD_W-1:0]  coefficient;
        logic               ready_res;
        logic [COUNT_W-1:0] filled_total;
    } readout_t;

    // Tracks the coefficient store and batch counters and holds the pending readouts.
    class coef_tracker;
        logic [COEF_W-1:0] coefs [TB_MAX_COEFS];
        int unsigned       fill_count;
        int unsigned       words_seen;
        logic [LOG_W-1:0]  log_reg;
        logic              bounded_reg;
        readout_t          pending_reads [$];
        int                errors;

        function new();
            log_reg     = 4'd9;
            bounded_reg = 1'b1;
            fill_count  = 0;
            words_seen  = 0;
            errors      = 0;
        endfunction

        function int unsigned eff_log();
            return (log_reg > TB_MAX_LOG) ? TB_MAX_LOG : int'(log_reg);
        endfunction

        function int unsigned degree();
            int unsigned n;
            n = 1 << eff_log();
            return (n > TB_MAX_COEFS) ? TB_MAX_COEFS : n;
        endfunction

        function int unsigned word_limit();
            return degree() + EXTRA_WORDS[eff_log()];
        endfunction

        // Bounded batches end on the word count, unbounded ones on a full store.
        function bit batch_done();
            if (bounded_reg)
                return words_seen >= word_limit();
            return fill_count >= degree();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_LOG_DEGREE)
                log_reg = data;
            else if (idx == CFG_BOUNDED_MODE)
                bounded_reg = data[0];
        endfunction

        // Applies one accepted item and queues the readout of a read.
        function void take_item(kind_t k, logic [WORD_W-1:0] w, logic [INDEX_W-1:0] idx);
            readout_t r;
            case (k)
                KIND_START:
                begin
                    fill_count = 0;
                    words_seen = 0;
                end
                KIND_PUSH:
                begin
                    if (!batch_done())
                    begin
                        if (words_seen < SAT_COUNT)
                            words_seen++;
                        if (w < REJECT_LIMIT && fill_count < degree())
                        begin
                            coefs[fill_count] = COEF_W'(w % MODULUS);
                            fill_count++;
                        end
                    end
                end
                KIND_READ:
                begin
                    if (idx < degree() && idx < fill_count)
                        r.coefficient = WORD_W'(coefs[idx]);
                    else
                        r.coefficient = EMPTY_SLOT;
                    r.ready_res    = batch_done();
                    r.filled_total = COUNT_W'(fill_count);
                    pending_reads.push_back(r);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void flag(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        // Compares one delivered result with the oldest pending readout.
        function void check_readout(logic [WORD_W-1:0] coef, logic rdy,
                                    logic [COUNT_W-1:0] total);
            readout_t want;
            if (pending_reads.size() == 0)
            begin
                $display("%0t ns: unexpected result: expected none, actual coefficient %0d",
                         $time, coef);
                errors++;
                return;
            end
            want = pending_reads.pop_front();
            if (coef !== want.coefficient)
                flag("coefficient", want.coefficient, coef);
            if (rdy !== want.ready_res)
                flag("ready_res", WORD_W'(want.ready_res), WORD_W'(rdy));
            if (total !== want.filled_total)
                flag("filled_total", WORD_W'(want.filled_total), WORD_W'(total));
        endfunction

        function void check_leftover();
            if (pending_reads.size() != 0)
            begin
                $display("%0t ns: missing results: expected %0d more, actual 0",
                         $time, pending_reads.size());
                errors += pending_reads.size();
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    htp_in_if  items_ch ();
    htp_out_if results_ch ();

    coef_tracker tracker = new();
    int          burst_left;
    int          items_sent;

    hash_to_point_sampler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items_ch),
        .results   (results_ch)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous run limit.
    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Register writes and accepted items update the tracker at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            tracker.write_reg(cfg_index, cfg_data);
        if (rst_n && items_ch.valid && items_ch.ready)
            tracker.take_item(kind_t'(items_ch.kind), items_ch.hash_word,
                              items_ch.read_index);
    end

    // Every delivered result is checked against the oldest pending readout.
    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
            tracker.check_readout(results_ch.coefficient, results_ch.ready_res,
                                  results_ch.filled_total);
    end

    // The result side stalls in stretches of varying patterns.
    initial
    begin
        int mode;
        int span;
        int k;
        int stall_len;
        results_ch.ready <= 1'b0;
        @(negedge clk);
        forever
        begin
            mode      = $urandom_range(0, 3);
            span      = $urandom_range(10, 200);
            k         = $urandom_range(2, 5);
            stall_len = $urandom_range(5, 20);
            for (int c = 0; c < span; c++)
            begin
                case (mode)
                    0:       results_ch.ready <= 1'b1;
                    1:       results_ch.ready <= 1'($urandom_range(0, 1));
                    2:       results_ch.ready <= (c % k == 0);
                    default: results_ch.ready <= (c >= stall_len);
                endcase
                @(negedge clk);
            end
        end
    end

    // Sends one item, with the sender working in bursts separated by gaps.
    task automatic send_item(input kind_t k, input logic [WORD_W-1:0] w,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                items_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 16);
        end
        items_ch.valid      <= 1'b1;
        items_ch.kind       <= k;
        items_ch.hash_word  <= w;
        items_ch.read_index <= idx;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    // Holds off the sender until every readout has arrived and pushes have settled.
    task automatic drain_results();
        items_ch.valid <= 1'b0;
        while (tracker.pending_reads.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes the selected registers on consecutive cycles; the block must be idle.
    task automatic write_regs(input bit set_log, input logic [LOG_W-1:0] log_val,
                              input bit set_bnd, input logic bnd_val);
        if (set_log)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_LOG_DEGREE;
            cfg_data  <= log_val;
            @(negedge clk);
        end
        if (set_bnd)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_BOUNDED_MODE;
            cfg_data  <= {3'($urandom_range(0, 7)), bnd_val};
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Hash words: mostly uniform, with rejected words and reduction edges favored.
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] edges [14] = '{16'd0, 16'd1, 16'd12288, 16'd12289, 16'd24577,
                                          16'd24578, 16'd36866, 16'd36867, 16'd49155,
                                          16'd49156, 16'd61444, 16'd61445, 16'd65535,
                                          16'd32768};
        case ($urandom_range(0, 19))
            0, 1, 2:       return WORD_W'($urandom_range(61445, 65535));
            3, 4, 5:       return edges[$urandom_range(0, 13)];
            6, 7:          return WORD_W'($urandom_range(0, 12288));
            default:       return WORD_W'($urandom);
        endcase
    endfunction

    // Read positions: mostly filled slots, also unfilled and out-of-range ones.
    function automatic logic [INDEX_W-1:0] pick_index();
        int unsigned n;
        int unsigned f;
        n = tracker.degree();
        f = tracker.fill_count;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return (f == 0) ? '0 : INDEX_W'($urandom_range(0, f - 1));
            5, 6:          return INDEX_W'($urandom_range(0, n - 1));
            7, 8:          return INDEX_W'($urandom);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return INDEX_W'(n - 1);
                    default: return INDEX_W'(f);
                endcase
            end
        endcase
    endfunction

    // Log degree choice: small sizes dominate, large and oversized values appear.
    function automatic logic [LOG_W-1:0] pick_log();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return LOG_W'($urandom_range(0, 4));
        if (roll < 80)
            return LOG_W'($urandom_range(5, 7));
        if (roll < 92)
            return LOG_W'($urandom_range(8, 10));
        return LOG_W'($urandom_range(11, 15));
    endfunction

    // One ordinary batch: new settings, a start, pushes mixed with reads, then readback.
    task automatic run_phase();
        int cap;
        int roll;
        drain_results();
        write_regs($urandom_range(0, 4) != 0, pick_log(),
                   $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) != 0)
            send_item(KIND_START, WORD_W'($urandom), INDEX_W'($urandom));
        // Large batches are left partly done so the next settings change lands mid-batch.
        cap = (tracker.word_limit() > 400) ? $urandom_range(1, 60) : 2000;
        while (!tracker.batch_done() && cap > 0 && items_sent < ITEM_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 22)
                send_item(KIND_READ, WORD_W'($urandom), pick_index());
            else if (roll < 24)
                send_item(KIND_NONE, WORD_W'($urandom), INDEX_W'($urandom));
            else if (roll < 25)
                send_item(KIND_START, WORD_W'($urandom), INDEX_W'($urandom));
            else
            begin
                send_item(KIND_PUSH, pick_word(), INDEX_W'($urandom));
                cap--;
            end
        end
        // Words after completion must be ignored.
        repeat ($urandom_range(0, 3))
            send_item(KIND_PUSH, pick_word(), INDEX_W'($urandom));
        repeat ($urandom_range(1, 5))
            send_item(KIND_READ, WORD_W'($urandom), pick_index());
    endtask

    // Fill a whole 64-slot batch unbounded, then finish it as a bounded batch.
    task automatic fill_whole_store();
        drain_results();
        write_regs(1'b1, 4'd6, 1'b1, 1'b0);
        send_item(KIND_START, WORD_W'($urandom), INDEX_W'($urandom));
        while (!tracker.batch_done())
        begin
            if ($urandom_range(0, 49) == 0)
                send_item(KIND_READ, WORD_W'($urandom), pick_index());
            else if ($urandom_range(0, 7) == 0)
                send_item(KIND_PUSH, WORD_W'($urandom_range(61445, 65535)), '0);
            else
                send_item(KIND_PUSH, WORD_W'($urandom_range(0, 61444)), '0);
        end
        send_item(KIND_READ, '0, '1);
        send_item(KIND_READ, '0, '0);
        send_item(KIND_READ, '0, pick_index());
        // Bounded with a full store: words are consumed but dropped until the limit.
        drain_results();
        write_regs(1'b0, '0, 1'b1, 1'b1);
        send_item(KIND_READ, '0, '1);
        while (!tracker.batch_done())
            send_item(KIND_PUSH, pick_word(), INDEX_W'($urandom));
        send_item(KIND_READ, '0, '1);
        send_item(KIND_READ, '0, 10'd63);
    endtask

    // Stimulus.
    initial
    begin
        int phase;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_LOG_DEGREE;
        cfg_data            <= '0;
        items_ch.valid      <= 1'b0;
        items_ch.kind       <= KIND_START;
        items_ch.hash_word  <= '0;
        items_ch.read_index <= '0;
        burst_left = 0;
        items_sent = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-coefficient bounded batch: one word ends it, even a rejected one.
        write_regs(1'b1, 4'd0, 1'b1, 1'b1);
        send_item(KIND_READ, '0, '0);
        send_item(KIND_START, '0, '0);
        send_item(KIND_PUSH, 16'd61445, '0);
        send_item(KIND_PUSH, 16'd5, '0);
        send_item(KIND_READ, '0, '0);
        send_item(KIND_NONE, 16'hFFFF, '1);
        send_item(KIND_READ, 16'hFFFF, '1);

        // Two coefficients unbounded: reduction edges, rejection, push after full.
        drain_results();
        write_regs(1'b1, 4'd1, 1'b1, 1'b0);
        send_item(KIND_START, '0, '0);
        send_item(KIND_PUSH, 16'd61444, '0);
        send_item(KIND_PUSH, 16'd65535, '0);
        send_item(KIND_PUSH, 16'd0, '0);
        send_item(KIND_PUSH, 16'd12289, '0);
        send_item(KIND_READ, '0, 10'd0);
        send_item(KIND_READ, '0, 10'd1);
        send_item(KIND_READ, '0, 10'd2);

        // Oversized log degree mid-batch: the store keeps filling past two slots.
        drain_results();
        write_regs(1'b1, 4'd15, 1'b0, 1'b0);
        send_item(KIND_PUSH, 16'd24577, '0);
        send_item(KIND_PUSH, 16'd24578, '0);
        send_item(KIND_PUSH, 16'd49155, '0);
        send_item(KIND_PUSH, 16'd49156, '0);
        send_item(KIND_PUSH, 16'd12288, '0);
        send_item(KIND_READ, '0, 10'd6);
        send_item(KIND_READ, '0, '1);
        send_item(KIND_READ, '0, 10'd2);

        // Random batches, with one full-store run mixed in early.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 1)
                fill_whole_store();
            else
                run_phase();
            phase++;
        end

        drain_results();
        repeat (8) @(negedge clk);
        tracker.check_leftover();
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
